>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, also checked across reset
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// shared widths, constants and the sideband record of the 3pl pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package irt_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [1:0] FUNC_PROB  = 2'd0;
  localparam logic [1:0] FUNC_INFO  = 2'd1;
  localparam logic [1:0] FUNC_DERIV = 2'd2;
  localparam logic [1:0] FUNC_VAR   = 2'd3;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // logit magnitude and its q.32 image
  localparam int MAG_W = FRAC_BITS + 6;
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(40 << FRAC_BITS);
  localparam int X_W = 38;
  localparam int K_W = 6;

  // exp series
  localparam int SERIES_TERMS = 14;
  localparam int SUM_W = 35;
  localparam logic [32:0] MAGIC [SERIES_TERMS] = '{
    33'((64'd1 << 32) / 1),
    33'((64'd1 << 33) / 2),
    33'(((64'd1 << 34) + 2) / 3),
    33'((64'd1 << 34) / 4),
    33'(((64'd1 << 35) + 4) / 5),
    33'(((64'd1 << 35) + 5) / 6),
    33'(((64'd1 << 35) + 6) / 7),
    33'((64'd1 << 35) / 8),
    33'(((64'd1 << 36) + 8) / 9),
    33'(((64'd1 << 36) + 9) / 10),
    33'(((64'd1 << 36) + 10) / 11),
    33'(((64'd1 << 36) + 11) / 12),
    33'(((64'd1 << 36) + 12) / 13),
    33'(((64'd1 << 36) + 13) / 14)
  };
  localparam int MSHIFT [SERIES_TERMS] = '{
    32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36, 36
  };

  // divider
  localparam int DIV_N_W = 64;
  localparam int DIV_Q_W = 61;
  localparam int DIV_D_W = 34;

  typedef struct packed {
    logic [1:0]  func;
    logic        resp;
    logic [23:0] a;
    logic [30:0] c30;
    logic        neg;
    logic [30:0] p;
    logic [31:0] val0;
    logic        inval;
    logic [30:0] t2;
  } irt_side_t;

endpackage

`default_nettype wire

>>> src/irt_div.sv
// ----------------------------------------------------------------------------
// irt_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
`default_nettype none

module irt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [irt_pkg::DIV_N_W-1:0]      num,
  input  logic [irt_pkg::DIV_D_W-1:0]      den,
  input  irt_pkg::irt_side_t               in_side,
  output logic                             out_valid,
  output logic [irt_pkg::DIV_Q_W-1:0]      quot,
  output irt_pkg::irt_side_t               out_side
);

  localparam int QW = irt_pkg::DIV_Q_W;
  localparam int DW = irt_pkg::DIV_D_W;
  localparam int NW = irt_pkg::DIV_N_W;

  logic              dv   [QW+1];
  logic [DW-1:0]     drem [QW+1];
  logic [QW-1:0]     dacc [QW+1];
  logic [DW-1:0]     dden [QW+1];
  irt_pkg::irt_side_t dside [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
    end
    drem[0]  <= DW'(num[NW-1:QW]);
    dacc[0]  <= num[QW-1:0];
    dden[0]  <= den;
    dside[0] <= in_side;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {drem[i], dacc[i][QW-1]};
      ge    = trial >= {1'b0, dden[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      drem[i+1]  <= ge ? DW'(trial - {1'b0, dden[i]}) : trial[DW-1:0];
      dacc[i+1]  <= {dacc[i][QW-2:0], ge};
      dden[i+1]  <= dden[i];
      dside[i+1] <= dside[i];
    end
  end

  assign out_valid = dv[QW];
  assign quot      = dacc[QW];
  assign out_side  = dside[QW];

endmodule

`default_nettype wire

>>> src/irt_exp.sv
// ----------------------------------------------------------------------------
// irt_exp
// e^-x in q.32: range reduction by ln2, 14-term series, final shift
// ----------------------------------------------------------------------------
`default_nettype none

module irt_exp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [irt_pkg::X_W-1:0]   x,
  input  irt_pkg::irt_side_t        in_side,
  output logic                      out_valid,
  output logic [32:0]               e,
  output irt_pkg::irt_side_t        out_side
);

  localparam int KS = irt_pkg::K_W;
  localparam int XW = irt_pkg::X_W;
  localparam int NT = irt_pkg::SERIES_TERMS;
  localparam int SW = irt_pkg::SUM_W;

  // range reduction
  logic               kv    [KS+1];
  logic [XW-1:0]      krem  [KS+1];
  logic [KS-1:0]      kq    [KS+1];
  irt_pkg::irt_side_t kside [KS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      kv[0] <= 1'b0;
    end else begin
      kv[0] <= in_valid;
    end
    krem[0]  <= x;
    kq[0]    <= '0;
    kside[0] <= in_side;
  end

  for (genvar j = 0; j < KS; j++) begin : g_k
    localparam logic [XW-1:0] SUB = XW'(irt_pkg::LN2_Q32) << (KS - 1 - j);
    logic ge;
    assign ge = krem[j] >= SUB;
    always_ff @(posedge clk) begin
      if (rst) begin
        kv[j+1] <= 1'b0;
      end else begin
        kv[j+1] <= kv[j];
      end
      krem[j+1]  <= ge ? krem[j] - SUB : krem[j];
      kq[j+1]    <= {kq[j][KS-2:0], ge};
      kside[j+1] <= kside[j];
    end
  end

  // series
  logic                  bv    [NT+1];
  logic [32:0]           bterm [NT+1];
  logic signed [SW-1:0]  bsum  [NT+1];
  logic [31:0]           br    [NT+1];
  logic [KS-1:0]         bk    [NT+1];
  irt_pkg::irt_side_t    bside [NT+1];

  logic                  av    [NT];
  logic [31:0]           am    [NT];
  logic signed [SW-1:0]  asum  [NT];
  logic [31:0]           ar    [NT];
  logic [KS-1:0]         ak    [NT];
  irt_pkg::irt_side_t    aside [NT];

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else begin
      bv[0] <= kv[KS];
    end
    bterm[0] <= 33'h1_0000_0000;
    bsum[0]  <= SW'(33'h1_0000_0000);
    br[0]    <= krem[KS][31:0];
    bk[0]    <= kq[KS];
    bside[0] <= kside[KS];
  end

  for (genvar i = 0; i < NT; i++) begin : g_term
    logic [32:0] q;
    assign q = 33'((65'(am[i]) * 65'(irt_pkg::MAGIC[i])) >> irt_pkg::MSHIFT[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        av[i]   <= 1'b0;
        bv[i+1] <= 1'b0;
      end else begin
        av[i]   <= bv[i];
        bv[i+1] <= av[i];
      end
      am[i]    <= 32'((65'(bterm[i]) * 65'(br[i])) >> 32);
      asum[i]  <= bsum[i];
      ar[i]    <= br[i];
      ak[i]    <= bk[i];
      aside[i] <= bside[i];

      bterm[i+1] <= q;
      if ((i % 2) == 0) begin
        bsum[i+1] <= asum[i] - SW'(q);
      end else begin
        bsum[i+1] <= asum[i] + SW'(q);
      end
      br[i+1]    <= ar[i];
      bk[i+1]    <= ak[i];
      bside[i+1] <= aside[i];
    end
  end

  logic [SW-2:0] sum_pos;
  assign sum_pos = bsum[NT][SW-1] ? '0 : bsum[NT][SW-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= bv[NT];
    end
    e        <= 33'(sum_pos >> bk[NT]);
    out_side <= bside[NT];
  end

endmodule

`default_nettype wire

>>> src/irt_three_param_logistic_unit.sv
// ----------------------------------------------------------------------------
// irt_three_param_logistic_unit
// 3pl item response unit: probability, fisher information, derivative,
// variance in unsigned q16.16
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high and busy is low; busy is
// high only during reset, so one transaction can enter every clock cycle.
// Each result appears on value, saturated and invalid for one cycle with done
// high, and is taken at the edge that ends that cycle; there is no back
// pressure on the result side. Most of the pipeline is the three 62-stage
// restoring dividers (sigmoid, normalization by 1-c, division by p), the rest
// is the 37-stage exponential series and a handful of multiply stages.
`default_nettype none

module irt_three_param_logistic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic               response,
  input  logic signed [23:0] ability,
  input  logic [23:0]        discrimination,
  input  logic signed [23:0] threshold,
  input  logic [16:0]        guessing,
  output logic               done,
  output logic [31:0]        value,
  output logic               saturated,
  output logic               invalid
);

  localparam int FB = irt_pkg::FRAC_BITS;

  assign busy = rst;

  // s1: capture
  logic               s1_valid;
  irt_pkg::irt_side_t s1_side;
  logic signed [23:0] s1_ability;
  logic signed [23:0] s1_b;
  irt_pkg::irt_side_t in_side;

  always_comb begin
    in_side       = '0;
    in_side.func  = func;
    in_side.resp  = response;
    in_side.a     = discrimination;
    in_side.c30   = (guessing > 17'd65536) ? irt_pkg::ONE30 : {guessing, 14'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_side    <= in_side;
    s1_ability <= ability;
    s1_b       <= threshold;
  end

  // s2: a * ability
  logic               s2_valid;
  irt_pkg::irt_side_t s2_side;
  logic signed [48:0] s2_prod;
  logic signed [23:0] s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod <= $signed({1'b0, s1_side.a}) * s1_ability;
    s2_b    <= s1_b;
    s2_side <= s1_side;
  end

  // s3: logit
  logic               s3_valid;
  irt_pkg::irt_side_t s3_side;
  logic signed [49:0] s3_logit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_logit <= 50'(s2_prod >>> FB) - 50'(s2_b);
    s3_side  <= s2_side;
  end

  // s4: magnitude, clamp, q.32
  logic                        s4_valid;
  irt_pkg::irt_side_t          s4_side;
  irt_pkg::irt_side_t          s4_side_next;
  logic [irt_pkg::X_W-1:0]     s4_x;
  logic [49:0]                 mag_full;
  logic [irt_pkg::MAG_W-1:0]   mag_c;

  always_comb begin
    mag_full = s3_logit[49] ? 50'(-s3_logit) : 50'(s3_logit);
    mag_c    = (mag_full > 50'(irt_pkg::MAG_MAX)) ? irt_pkg::MAG_MAX
                                                  : mag_full[irt_pkg::MAG_W-1:0];
    s4_side_next     = s3_side;
    s4_side_next.neg = s3_logit[49];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_x    <= irt_pkg::X_W'({mag_c, {(32 - FB){1'b0}}});
    s4_side <= s4_side_next;
  end

  // exponential
  logic               e_valid;
  logic [32:0]        e_val;
  irt_pkg::irt_side_t e_side;

  irt_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_valid),
    .x         (s4_x),
    .in_side   (s4_side),
    .out_valid (e_valid),
    .e         (e_val),
    .out_side  (e_side)
  );

  // s5: sigmoid division operands
  logic                          s5_valid;
  irt_pkg::irt_side_t            s5_side;
  logic [irt_pkg::DIV_N_W-1:0]   s5_num;
  logic [irt_pkg::DIV_D_W-1:0]   s5_den;
  logic [33:0]                   den5;

  assign den5 = 34'h1_0000_0000 + 34'(e_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= e_valid;
    end
    s5_den  <= den5;
    s5_num  <= e_side.neg ? 64'({e_val, 30'b0}) + 64'(den5 >> 1)
                          : (64'd1 << 62) + 64'(den5 >> 1);
    s5_side <= e_side;
  end

  logic                          d1_valid;
  logic [irt_pkg::DIV_Q_W-1:0]   d1_quot;
  irt_pkg::irt_side_t            d1_side;

  irt_div u_div_sig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .num       (s5_num),
    .den       (s5_den),
    .in_side   (s5_side),
    .out_valid (d1_valid),
    .quot      (d1_quot),
    .out_side  (d1_side)
  );

  // s6: (1-c) * s
  logic               s6_valid;
  irt_pkg::irt_side_t s6_side;
  logic [61:0]        s6_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= d1_valid;
    end
    s6_prod <= 62'(irt_pkg::ONE30 - d1_side.c30) * 62'(d1_quot[30:0]);
    s6_side <= d1_side;
  end

  // s7: p
  logic               s7_valid;
  irt_pkg::irt_side_t s7_side;
  irt_pkg::irt_side_t s7_side_next;

  always_comb begin
    s7_side_next   = s6_side;
    s7_side_next.p = s6_side.c30 + 31'((63'(s6_prod) + (63'(1) << 29)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_side <= s7_side_next;
  end

  // s8: (p-c)(1-p) or p(1-p)
  logic               s8_valid;
  irt_pkg::irt_side_t s8_side;
  logic [61:0]        s8_prod;
  logic [30:0]        s8_x;

  assign s8_x = (s7_side.func == irt_pkg::FUNC_VAR) ? s7_side.p
                                                     : s7_side.p - s7_side.c30;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    s8_prod <= 62'(s8_x) * 62'(irt_pkg::ONE30 - s7_side.p);
    s8_side <= s7_side;
  end

  // s9: simple results, flags, second division operands
  logic                          s9_valid;
  irt_pkg::irt_side_t            s9_side;
  irt_pkg::irt_side_t            s9_side_next;
  logic [irt_pkg::DIV_N_W-1:0]   s9_num;
  logic [irt_pkg::DIV_D_W-1:0]   s9_den;
  logic [30:0]                   t9;
  logic [30:0]                   q9;
  logic                          inval9;

  always_comb begin
    t9 = s8_prod[60:30];
    if (s8_side.func == irt_pkg::FUNC_PROB) begin
      q9 = s8_side.resp ? s8_side.p : irt_pkg::ONE30 - s8_side.p;
    end else begin
      q9 = t9;
    end
    inval9 = ((s8_side.c30 == irt_pkg::ONE30) &&
              ((s8_side.func == irt_pkg::FUNC_INFO) || (s8_side.func == irt_pkg::FUNC_DERIV)))
          || ((s8_side.p == '0) && (s8_side.func == irt_pkg::FUNC_INFO));
    s9_side_next       = s8_side;
    s9_side_next.val0  = 32'((32'(q9) + (32'(1) << (29 - FB))) >> (30 - FB));
    s9_side_next.inval = inval9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_side <= s9_side_next;
    s9_num <= {3'b0, (s8_side.func == irt_pkg::FUNC_INFO) ? s8_side.p - s8_side.c30 : t9,
               30'b0};
    s9_den <= {3'b0, irt_pkg::ONE30 - s8_side.c30};
  end

  logic                          d2_valid;
  logic [irt_pkg::DIV_Q_W-1:0]   d2_quot;
  irt_pkg::irt_side_t            d2_side;

  irt_div u_div_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_valid),
    .num       (s9_num),
    .den       (s9_den),
    .in_side   (s9_side),
    .out_valid (d2_valid),
    .quot      (d2_quot),
    .out_side  (d2_side)
  );

  // s10: u*u
  logic               s10_valid;
  irt_pkg::irt_side_t s10_side;
  irt_pkg::irt_side_t s10_side_next;
  logic [61:0]        s10_uu;

  always_comb begin
    s10_side_next    = d2_side;
    s10_side_next.t2 = d2_quot[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else begin
      s10_valid <= d2_valid;
    end
    s10_uu   <= 62'(d2_quot[30:0]) * 62'(d2_quot[30:0]);
    s10_side <= s10_side_next;
  end

  // s11: (1-p) * v
  logic               s11_valid;
  irt_pkg::irt_side_t s11_side;
  logic [61:0]        s11_wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else begin
      s11_valid <= s10_valid;
    end
    s11_wp   <= 62'(irt_pkg::ONE30 - s10_side.p) * 62'(s10_uu[60:30]);
    s11_side <= s10_side;
  end

  // s12: third division operands
  logic                          s12_valid;
  irt_pkg::irt_side_t            s12_side;
  logic [irt_pkg::DIV_N_W-1:0]   s12_num;
  logic [irt_pkg::DIV_D_W-1:0]   s12_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else begin
      s12_valid <= s11_valid;
    end
    s12_num  <= {2'b0, s11_wp[61:30], 30'b0};
    s12_den  <= {3'b0, s11_side.p};
    s12_side <= s11_side;
  end

  logic                          d3_valid;
  logic [irt_pkg::DIV_Q_W-1:0]   d3_quot;
  irt_pkg::irt_side_t            d3_side;

  irt_div u_div_p (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s12_valid),
    .num       (s12_num),
    .den       (s12_den),
    .in_side   (s12_side),
    .out_valid (d3_valid),
    .quot      (d3_quot),
    .out_side  (d3_side)
  );

  // s13: a * operand, two partial products
  logic               s13_valid;
  irt_pkg::irt_side_t s13_side;
  logic [54:0]        s13_pl;
  logic [53:0]        s13_ph;
  logic [60:0]        opnd13;

  assign opnd13 = (d3_side.func == irt_pkg::FUNC_INFO) ? d3_quot : {30'b0, d3_side.t2};

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_valid <= 1'b0;
    end else begin
      s13_valid <= d3_valid;
    end
    s13_pl   <= 55'(d3_side.a) * 55'(opnd13[30:0]);
    s13_ph   <= 54'(d3_side.a) * 54'(opnd13[60:31]);
    s13_side <= d3_side;
  end

  // s14: combine
  logic               s14_valid;
  irt_pkg::irt_side_t s14_side;
  logic [84:0]        s14_x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_valid <= 1'b0;
    end else begin
      s14_valid <= s13_valid;
    end
    s14_x1   <= 85'(s13_pl) + (85'(s13_ph) << 31);
    s14_side <= s13_side;
  end

  // s15: a * x1, three partial products
  logic               s15_valid;
  irt_pkg::irt_side_t s15_side;
  logic [52:0]        s15_p0;
  logic [52:0]        s15_p1;
  logic [50:0]        s15_p2;
  logic [84:0]        s15_x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s15_valid <= 1'b0;
    end else begin
      s15_valid <= s14_valid;
    end
    s15_p0   <= 53'(s14_side.a) * 53'(s14_x1[28:0]);
    s15_p1   <= 53'(s14_side.a) * 53'(s14_x1[57:29]);
    s15_p2   <= 51'(s14_side.a) * 51'(s14_x1[84:58]);
    s15_x1   <= s14_x1;
    s15_side <= s14_side;
  end

  // s16: combine
  logic               s16_valid;
  irt_pkg::irt_side_t s16_side;
  logic [109:0]       s16_x2;
  logic [84:0]        s16_x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s16_valid <= 1'b0;
    end else begin
      s16_valid <= s15_valid;
    end
    s16_x2   <= 110'(s15_p0) + (110'(s15_p1) << 29) + (110'(s15_p2) << 58);
    s16_x1   <= s15_x1;
    s16_side <= s15_side;
  end

  // output: round, saturate, flag
  logic [109:0] r_info;
  logic [85:0]  r_deriv;
  logic [109:0] r_big;
  logic         r_sat;

  always_comb begin
    r_info  = (s16_x2 + (110'(1) << (FB + 29))) >> (FB + 30);
    r_deriv = (86'(s16_x1) + (86'(1) << 29)) >> 30;
    case (s16_side.func)
      irt_pkg::FUNC_INFO:  r_big = r_info;
      irt_pkg::FUNC_DERIV: r_big = 110'(r_deriv);
      default:             r_big = 110'(s16_side.val0);
    endcase
    r_sat = |r_big[109:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s16_valid;
    end
    if (s16_side.inval) begin
      value     <= '0;
      saturated <= 1'b0;
    end else begin
      value     <= r_sat ? 32'hFFFF_FFFF : r_big[31:0];
      saturated <= r_sat;
    end
    invalid <= s16_side.inval;
  end

endmodule

`default_nettype wire

>>> src/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker
// port-level checks on the result channel of the 3pl unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module irt_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [31:0] value,
  input logic        saturated,
  input logic        invalid
);

  `ASSERT_IMP(a_inval_zero, done && invalid, (value == 32'd0) && !saturated, "invalid with data")
  `ASSERT_IMP(a_sat_clip, done && saturated, (value == 32'hFFFF_FFFF) && !invalid, "bad clip")
  `ASSERT_NXT(a_rst_quiet, rst, !done, "result after reset")

endmodule

bind irt_three_param_logistic_unit irt_checker u_irt_checker (.*);

`default_nettype wire
